// ----- rtl/vxr_pkg.sv -----
// ----------------------------------------------------------------------------
// vxr_pkg: shared types and constants for the vertex XYZ rotation unit
// Coordinate and trig formats, coefficient bundles and register map.
// ----------------------------------------------------------------------------
package vxr_pkg;

   // Coordinate format: signed Q16.16
   localparam int COORD_WIDTH    = 32;
   // Trig coefficient format: signed Q2.14
   localparam int TRIG_WIDTH     = 16;
   localparam int TRIG_FRAC_BITS = 14;

   // Configuration port
   localparam int CSR_DATA_WIDTH = 32;
   localparam int CSR_ADDR_WIDTH = 5;
   localparam int CSR_IDX_WIDTH  = 3;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [TRIG_WIDTH-1:0]  trig_type;

   // Register indexes
   typedef logic [CSR_IDX_WIDTH-1:0] csr_idx_type;
   localparam csr_idx_type REG_COS_X = 3'd0;
   localparam csr_idx_type REG_SIN_X = 3'd1;
   localparam csr_idx_type REG_COS_Y = 3'd2;
   localparam csr_idx_type REG_SIN_Y = 3'd3;
   localparam csr_idx_type REG_COS_Z = 3'd4;
   localparam csr_idx_type REG_SIN_Z = 3'd5;

   // Reset value of a cosine register: one in trig format
   localparam trig_type TRIG_ONE = trig_type'(1) <<< TRIG_FRAC_BITS;

   // One rotation's coefficient pair
   typedef struct packed {
      trig_type cos_val;
      trig_type sin_val;
   } rot_coef_type;

   // All three rotations, as the register block hands them out
   typedef struct packed {
      rot_coef_type about_x;
      rot_coef_type about_y;
      rot_coef_type about_z;
   } rot_coef_set_type;

endpackage

// ----- rtl/vxr_csr.sv -----
// ----------------------------------------------------------------------------
// vxr_csr: coefficient register block
// APB-style register file holding cosine and sine of the three angles.
// ----------------------------------------------------------------------------
module vxr_csr
   import vxr_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                      csr_pready,
   output rot_coef_set_type          coef
);

   trig_type    cos_x_ff, sin_x_ff, cos_y_ff, sin_y_ff, cos_z_ff, sin_z_ff;
   csr_idx_type reg_idx;
   logic        wr_beat;
   trig_type    wr_val;
   trig_type    rd_val;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[CSR_ADDR_WIDTH-1:2];
   assign wr_beat    = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign wr_val     = trig_type'(csr_pwdata[TRIG_WIDTH-1:0]);

   // Write a register on the access beat; drop writes past the map
   always_ff @(posedge clock) begin
      if (reset) begin
         cos_x_ff <= TRIG_ONE;
         sin_x_ff <= '0;
         cos_y_ff <= TRIG_ONE;
         sin_y_ff <= '0;
         cos_z_ff <= TRIG_ONE;
         sin_z_ff <= '0;
      end else if (wr_beat) begin
         unique case (reg_idx)
            REG_COS_X: cos_x_ff <= wr_val;
            REG_SIN_X: sin_x_ff <= wr_val;
            REG_COS_Y: cos_y_ff <= wr_val;
            REG_SIN_Y: sin_y_ff <= wr_val;
            REG_COS_Z: cos_z_ff <= wr_val;
            REG_SIN_Z: sin_z_ff <= wr_val;
            default: ;
         endcase
      end
   end

   // Read back, sign-extended to the bus
   always_comb begin
      unique case (reg_idx)
         REG_COS_X: rd_val = cos_x_ff;
         REG_SIN_X: rd_val = sin_x_ff;
         REG_COS_Y: rd_val = cos_y_ff;
         REG_SIN_Y: rd_val = sin_y_ff;
         REG_COS_Z: rd_val = cos_z_ff;
         REG_SIN_Z: rd_val = sin_z_ff;
         default:   rd_val = '0;
      endcase
   end
   assign csr_prdata = CSR_DATA_WIDTH'(rd_val);

   assign coef.about_x = '{cos_val: cos_x_ff, sin_val: sin_x_ff};
   assign coef.about_y = '{cos_val: cos_y_ff, sin_val: sin_y_ff};
   assign coef.about_z = '{cos_val: cos_z_ff, sin_val: sin_z_ff};

endmodule

// ----- rtl/vxr_rot_stage.sv -----
// ----------------------------------------------------------------------------
// vxr_rot_stage: one plane rotation, two pipeline stages
// Stage 1 forms four products; stage 2 sums, rounds and saturates:
//   new_a = c*u - s*v,  new_b = s*u + c*v,  w passes unchanged.
// ----------------------------------------------------------------------------
module vxr_rot_stage
   import vxr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   input  coord_type    in_u,
   input  coord_type    in_v,
   input  coord_type    in_w,
   input  rot_coef_type coef,
   output logic         out_valid,
   output coord_type    out_a,
   output coord_type    out_b,
   output coord_type    out_w
);

   localparam int PROD_WIDTH = COORD_WIDTH + TRIG_WIDTH;
   localparam int SUM_WIDTH  = PROD_WIDTH + 2;
   localparam int PAD_WIDTH  = SUM_WIDTH - COORD_WIDTH + 1;

   typedef logic signed [PROD_WIDTH-1:0] prod_type;
   typedef logic signed [SUM_WIDTH-1:0]  sum_type;

   localparam sum_type HALF_LSB = sum_type'(1) <<< (TRIG_FRAC_BITS - 1);
   localparam sum_type SAT_HI   = {{PAD_WIDTH{1'b0}}, {(COORD_WIDTH-1){1'b1}}};
   localparam sum_type SAT_LO   = {{PAD_WIDTH{1'b1}}, {(COORD_WIDTH-1){1'b0}}};

   // Product stage
   logic      mul_valid_ff;
   prod_type  cu_ff, sv_ff, su_ff, cv_ff;
   coord_type mul_w_ff;

   // Round and saturate stage
   logic      sum_valid_ff;
   coord_type a_ff, b_ff, w_ff;
   sum_type   sum_a, sum_b, shr_a, shr_b;
   coord_type a_in, b_in;

   // Advance valid bits every cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
         sum_valid_ff <= 1'b0;
      end else begin
         mul_valid_ff <= in_valid;
         sum_valid_ff <= mul_valid_ff;
      end
   end

   // Form the four products
   always_ff @(posedge clock) begin
      cu_ff    <= prod_type'(coef.cos_val) * prod_type'(in_u);
      sv_ff    <= prod_type'(coef.sin_val) * prod_type'(in_v);
      su_ff    <= prod_type'(coef.sin_val) * prod_type'(in_u);
      cv_ff    <= prod_type'(coef.cos_val) * prod_type'(in_v);
      mul_w_ff <= in_w;
   end

   // Sum exactly, add half an LSB, floor-shift back to Q16.16
   assign sum_a = sum_type'(cu_ff) - sum_type'(sv_ff) + HALF_LSB;
   assign sum_b = sum_type'(su_ff) + sum_type'(cv_ff) + HALF_LSB;
   assign shr_a = sum_a >>> TRIG_FRAC_BITS;
   assign shr_b = sum_b >>> TRIG_FRAC_BITS;

   // Clamp to the coordinate range
   always_comb begin
      if (shr_a > SAT_HI) begin
         a_in = coord_type'(SAT_HI);
      end else if (shr_a < SAT_LO) begin
         a_in = coord_type'(SAT_LO);
      end else begin
         a_in = coord_type'(shr_a);
      end
      if (shr_b > SAT_HI) begin
         b_in = coord_type'(SAT_HI);
      end else if (shr_b < SAT_LO) begin
         b_in = coord_type'(SAT_LO);
      end else begin
         b_in = coord_type'(shr_b);
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
      w_ff <= mul_w_ff;
   end

   assign out_valid = sum_valid_ff;
   assign out_a     = a_ff;
   assign out_b     = b_ff;
   assign out_w     = w_ff;

endmodule

// ----- rtl/vertex_xyz_rotation_unit.sv -----
// Latency: six register stages lie between the accepted input beat and the result beat.
// Throughput: one vertex per cycle; busy stays low, start may be held every cycle.
// Each rotation (X, then Y, then Z) takes two stages: multiply, then round/saturate.
// Results cannot be stalled; each is shown for one cycle with rsp_strobe.
// Reset (synchronous) drops all vertices in flight and restores identity coefficients.
// ----------------------------------------------------------------------------
// vertex_xyz_rotation_unit: Euler XYZ rotation of Q16.16 vertices
// Three chained plane rotations with Q2.14 coefficients from registers.
// ----------------------------------------------------------------------------
module vertex_xyz_rotation_unit
   import vxr_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   // Vertex input
   input  logic                      start,
   output logic                      busy,
   input  coord_type                 req_pos_x,
   input  coord_type                 req_pos_y,
   input  coord_type                 req_pos_z,
   // Rotated vertex output
   output logic                      rsp_strobe,
   output coord_type                 rsp_rot_x,
   output coord_type                 rsp_rot_y,
   output coord_type                 rsp_rot_z,
   // Configuration
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                      csr_pready
);

   rot_coef_set_type coef;
   logic             in_beat;
   logic             vx_valid, vy_valid;
   coord_type        x1, y1, z1;
   coord_type        x2, y2, z2;

   // The pipeline never stalls, so a beat is taken every cycle it is offered
   assign busy    = 1'b0;
   assign in_beat = start & ~busy;

   vxr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .coef        (coef)
   );

   // About X: y' = c*y - s*z, z' = s*y + c*z
   vxr_rot_stage u_rot_x (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_beat),
      .in_u      (req_pos_y),
      .in_v      (req_pos_z),
      .in_w      (req_pos_x),
      .coef      (coef.about_x),
      .out_valid (vx_valid),
      .out_a     (y1),
      .out_b     (z1),
      .out_w     (x1)
   );

   // About Y: z' = c*z - s*x, x' = s*z + c*x
   vxr_rot_stage u_rot_y (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vx_valid),
      .in_u      (z1),
      .in_v      (x1),
      .in_w      (y1),
      .coef      (coef.about_y),
      .out_valid (vy_valid),
      .out_a     (z2),
      .out_b     (x2),
      .out_w     (y2)
   );

   // About Z: x' = c*x - s*y, y' = s*x + c*y
   vxr_rot_stage u_rot_z (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vy_valid),
      .in_u      (x2),
      .in_v      (y2),
      .in_w      (z2),
      .coef      (coef.about_z),
      .out_valid (rsp_strobe),
      .out_a     (rsp_rot_x),
      .out_b     (rsp_rot_y),
      .out_w     (rsp_rot_z)
   );

endmodule

// ----- tb/sv/tb_vertex_xyz_rotation_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_vertex_xyz_rotation_unit: self-checking bench for the XYZ rotation unit
// Programs the six trig registers over the APB port, streams Q16.16 vertices
// with random start gaps, and checks every rotated vertex against an in-bench
// fixed-point predictor (round half up, saturate after every stage).
// ----------------------------------------------------------------------------
module tb_vertex_xyz_rotation_unit;
   import vxr_pkg::*;

   localparam int      CLK_HALF     = 4;
   localparam int      RESET_CYCLES = 5;
   localparam int      PIPE_LATENCY = 6;
   localparam int      CYCLE_LIMIT  = 200000;
   localparam int      NUM_REGS     = REG_SIN_Z + 1;
   localparam int      GAP_MAX      = 7;
   // Unmapped register indexes inside the address window
   localparam csr_idx_type REG_SPARE_LO = 3'd6;
   localparam csr_idx_type REG_SPARE_HI = 3'd7;
   localparam coord_type COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
   localparam coord_type COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
   localparam trig_type  TRIG_HALF = TRIG_ONE >>> 1;

   typedef struct {
      coord_type x;
      coord_type y;
      coord_type z;
   } vertex_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   coord_type                 req_pos_x = '0;
   coord_type                 req_pos_y = '0;
   coord_type                 req_pos_z = '0;
   logic                      rsp_strobe;
   coord_type                 rsp_rot_x;
   coord_type                 rsp_rot_y;
   coord_type                 rsp_rot_z;
   logic                      csr_psel    = 1'b0;
   logic                      csr_penable = 1'b0;
   logic                      csr_pwrite  = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr   = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic                      csr_pready;

   // Bench copy of the coefficient registers and the rotated vertices in flight
   trig_type   coef_shadow [NUM_REGS];
   vertex_type rotated_q [$];

   int error_count     = 0;
   int vertices_sent   = 0;
   int vertices_seen   = 0;
   int csr_writes      = 0;
   int spare_writes    = 0;
   int settings_used   = 0;
   int gap_limit       = 0;
   int cycle_count     = 0;

   vertex_xyz_rotation_unit dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_pos_x   (req_pos_x),
      .req_pos_y   (req_pos_y),
      .req_pos_z   (req_pos_z),
      .rsp_strobe  (rsp_strobe),
      .rsp_rot_x   (rsp_rot_x),
      .rsp_rot_y   (rsp_rot_y),
      .rsp_rot_z   (rsp_rot_z),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Free-running clock, 8 ns period
   always begin
      #CLK_HALF clock = 1'b1;
      #CLK_HALF clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------

   // One rotated coordinate: round((a*c + b*s) / 2^F) half up, then saturate
   function automatic coord_type rotate_term(coord_type a, longint c, coord_type b, longint s);
      longint acc;
      acc = longint'(a) * c + longint'(b) * s + (longint'(1) << (TRIG_FRAC_BITS - 1));
      acc = acc >>> TRIG_FRAC_BITS;
      if (acc > longint'(COORD_MAX)) return COORD_MAX;
      if (acc < longint'(COORD_MIN)) return COORD_MIN;
      return coord_type'(acc);
   endfunction

   // Rotate about X, then Y, then Z with the current register contents
   function automatic vertex_type rotate_vertex(coord_type x, coord_type y, coord_type z);
      longint     cx, sx, cy, sy, cz, sz;
      coord_type  y1, z1, x2, z2;
      vertex_type v;
      cx = longint'(coef_shadow[REG_COS_X]);
      sx = longint'(coef_shadow[REG_SIN_X]);
      cy = longint'(coef_shadow[REG_COS_Y]);
      sy = longint'(coef_shadow[REG_SIN_Y]);
      cz = longint'(coef_shadow[REG_COS_Z]);
      sz = longint'(coef_shadow[REG_SIN_Z]);
      y1  = rotate_term(y, cx, z, -sx);
      z1  = rotate_term(y, sx, z, cx);
      x2  = rotate_term(x, cy, z1, sy);
      z2  = rotate_term(z1, cy, x, -sy);
      v.x = rotate_term(x2, cz, y1, -sz);
      v.y = rotate_term(x2, sz, y1, cz);
      v.z = z2;
      return v;
   endfunction

   // ------------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------------

   task automatic report_mismatch(input string msg);
      $display("ERROR @%0t: %s", $time, msg);
      error_count++;
   endtask

   task automatic check_field(input string name, input coord_type got, input coord_type want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
   endtask

   // Compare each result beat with the oldest pending vertex
   always @(posedge clock) begin : result_check
      vertex_type want;
      if (!reset && rsp_strobe) begin
         if (rotated_q.size() == 0) begin
            report_mismatch("result beat with no vertex pending");
         end else begin
            want = rotated_q.pop_front();
            check_field("rot_x", rsp_rot_x, want.x);
            check_field("rot_y", rsp_rot_y, want.y);
            check_field("rot_z", rsp_rot_z, want.z);
            vertices_seen++;
         end
      end
   end

   // Watchdog: end the run if it never settles
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timeout after %0d cycles, %0d vertices pending", cycle_count, rotated_q.size());
      $display("DONE: errors detected");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------------

   // Send one vertex beat after a random gap; record its rotation on accept
   task automatic send_vertex(input coord_type x, input coord_type y, input coord_type z);
      int gap;
      gap = $urandom_range(0, gap_limit);
      repeat (gap) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start     <= 1'b1;
      req_pos_x <= x;
      req_pos_y <= y;
      req_pos_z <= z;
      do @(posedge clock); while (busy);
      rotated_q.push_back(rotate_vertex(x, y, z));
      vertices_sent++;
   endtask

   // Drop start and wait until every pending vertex has come back
   task automatic drain_pipeline();
      @(negedge clock);
      start <= 1'b0;
      while (rotated_q.size() != 0) @(posedge clock);
   endtask

   // APB write: setup then access; upper data bits are random filler
   task automatic csr_write(input csr_idx_type idx, input trig_type value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= {16'($urandom), value};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (idx < NUM_REGS)
         coef_shadow[idx] = value;
      else
         spare_writes++;
      csr_writes++;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // APB read of one register; compare its trig bits with the shadow copy
   task automatic csr_read_check(input csr_idx_type idx);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata[TRIG_WIDTH-1:0] !== coef_shadow[idx])
         report_mismatch($sformatf("register %0d read %0d expected %0d", idx,
                                   $signed(csr_prdata[TRIG_WIDTH-1:0]), coef_shadow[idx]));
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Program all three rotations while idle, then read them back
   task automatic load_rotation(input trig_type cx, input trig_type sx, input trig_type cy,
                                input trig_type sy, input trig_type cz, input trig_type sz);
      drain_pipeline();
      csr_write(REG_COS_X, cx);
      csr_write(REG_SIN_X, sx);
      csr_write(REG_COS_Y, cy);
      csr_write(REG_SIN_Y, sy);
      csr_write(REG_COS_Z, cz);
      csr_write(REG_SIN_Z, sz);
      for (int i = 0; i < NUM_REGS; i++)
         csr_read_check(csr_idx_type'(i));
      settings_used++;
   endtask

   function automatic coord_type pick_coord();
      case ($urandom_range(0, 9))
         0:       return COORD_MAX;
         1:       return COORD_MIN;
         2:       return coord_type'($urandom_range(0, 1 << 19)) - coord_type'(1 << 18);
         3:       return coord_type'($urandom_range(0, 1 << 25)) - coord_type'(1 << 24);
         default: return coord_type'($urandom);
      endcase
   endfunction

   function automatic trig_type pick_trig();
      case ($urandom_range(0, 9))
         0:       return TRIG_ONE;
         1:       return -TRIG_ONE;
         2:       return '0;
         3:       return trig_type'($urandom);
         default: return trig_type'($urandom_range(0, 2 * TRIG_ONE) - TRIG_ONE);
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Reset leaves the identity rotation: vertices pass through unchanged
   task automatic test_identity_after_reset();
      for (int i = 0; i < NUM_REGS; i++)
         csr_read_check(csr_idx_type'(i));
      gap_limit = 0;
      send_vertex(COORD_MAX, COORD_MIN, '0);
      send_vertex(COORD_MIN, COORD_MAX, -1);
      send_vertex(1, -1, COORD_MAX);
      send_vertex('0, '0, COORD_MIN);
      send_vertex(coord_type'($urandom), coord_type'($urandom), coord_type'($urandom));
      send_vertex(~coord_type'(0), 1 <<< 16, -(1 <<< 16));
      drain_pipeline();
   endtask

   // Write every register and both unmapped slots; unmapped writes change nothing
   task automatic test_register_file();
      drain_pipeline();
      for (int i = 0; i < NUM_REGS; i++) begin
         csr_write(csr_idx_type'(i), trig_type'($urandom));
         csr_read_check(csr_idx_type'(i));
      end
      csr_write(REG_SPARE_LO, trig_type'($urandom));
      csr_write(REG_SPARE_HI, trig_type'($urandom));
      for (int i = 0; i < NUM_REGS; i++)
         csr_read_check(csr_idx_type'(i));
      gap_limit = GAP_MAX;
      send_vertex(pick_coord(), pick_coord(), pick_coord());
      drain_pipeline();
   endtask

   // Quarter turns about each axis in turn, one of them negative
   task automatic test_quarter_turns();
      gap_limit = 0;
      load_rotation('0, TRIG_ONE, TRIG_ONE, '0, TRIG_ONE, '0);
      send_vertex(1 <<< 16, 2 <<< 16, 3 <<< 16);
      send_vertex(COORD_MAX, COORD_MIN, COORD_MAX);
      load_rotation(TRIG_ONE, '0, '0, TRIG_ONE, TRIG_ONE, '0);
      send_vertex(1 <<< 16, 2 <<< 16, 3 <<< 16);
      send_vertex(COORD_MIN, COORD_MAX, COORD_MIN);
      load_rotation(TRIG_ONE, '0, TRIG_ONE, '0, '0, -TRIG_ONE);
      send_vertex(1 <<< 16, 2 <<< 16, 3 <<< 16);
      send_vertex(COORD_MIN, COORD_MIN, 5);
   endtask

   // Trig patterns beyond one in magnitude, including the most negative code
   task automatic test_wild_trig_values();
      gap_limit = 0;
      load_rotation(16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000);
      send_vertex(COORD_MAX, COORD_MAX, COORD_MAX);
      send_vertex(COORD_MIN, COORD_MIN, COORD_MIN);
      send_vertex(COORD_MAX, COORD_MIN, 1);
      send_vertex(-1, 12345, -54321);
   endtask

   // Exact halves round toward plus infinity
   task automatic test_rounding_ties();
      gap_limit = 0;
      load_rotation(TRIG_HALF, '0, TRIG_ONE, '0, TRIG_ONE, '0);
      send_vertex(1, 1, -1);
      send_vertex(-3, 3, -3);
      send_vertex(7, -5, 5);
   endtask

   // Stage results past the coordinate range clamp to the nearest bound
   task automatic test_saturation();
      gap_limit = 0;
      load_rotation(TRIG_ONE, TRIG_ONE, TRIG_ONE, TRIG_ONE, TRIG_ONE, TRIG_ONE);
      send_vertex(COORD_MAX, COORD_MAX, COORD_MIN);
      send_vertex(COORD_MIN, COORD_MIN, COORD_MAX);
      send_vertex(COORD_MAX, COORD_MAX, COORD_MAX);
      send_vertex(COORD_MIN, COORD_MIN, COORD_MIN);
   endtask

   // Random vertex streams under a series of settings, back-to-back and gapped
   task automatic test_random_streams();
      for (int phase = 0; phase < 9; phase++) begin
         case (phase)
            0:       load_rotation(-TRIG_ONE, -TRIG_ONE, -TRIG_ONE,
                                   -TRIG_ONE, -TRIG_ONE, -TRIG_ONE);
            1:       load_rotation(TRIG_ONE, TRIG_ONE, TRIG_ONE,
                                   TRIG_ONE, TRIG_ONE, TRIG_ONE);
            default: load_rotation(pick_trig(), pick_trig(), pick_trig(),
                                   pick_trig(), pick_trig(), pick_trig());
         endcase
         for (int n = 0; n < 50; n++) begin
            // Alternate stretches of back-to-back beats and random gaps
            if (n % 10 == 0)
               gap_limit = ((phase + n / 10) % 2 == 0) ? 0 : GAP_MAX;
            send_vertex(pick_coord(), pick_coord(), pick_coord());
         end
      end
      drain_pipeline();
   endtask

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------
   initial begin
      coef_shadow[REG_COS_X] = TRIG_ONE;
      coef_shadow[REG_SIN_X] = '0;
      coef_shadow[REG_COS_Y] = TRIG_ONE;
      coef_shadow[REG_SIN_Y] = '0;
      coef_shadow[REG_COS_Z] = TRIG_ONE;
      coef_shadow[REG_SIN_Z] = '0;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      test_identity_after_reset();
      test_register_file();
      test_quarter_turns();
      test_wild_trig_values();
      test_rounding_ties();
      test_saturation();
      test_random_streams();

      // Hold a little longer to catch stray result beats
      drain_pipeline();
      repeat (2 * PIPE_LATENCY + 4) @(posedge clock);
      if (rotated_q.size() != 0)
         report_mismatch($sformatf("%0d vertices never returned", rotated_q.size()));

      $display("Covered %0d vertices (%0d checked) under %0d rotation settings,",
               vertices_sent, vertices_seen, settings_used);
      $display("with %0d register writes, %0d of them to unmapped slots, in %0d cycles",
               csr_writes, spare_writes, cycle_count);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
